/* rtl/script_resource_validator_core_macros.svh */
// Assertion macros used by the port-level checker of the validator core.
`ifndef SCRIPT_RESOURCE_VALIDATOR_CORE_MACROS_SVH
`define SCRIPT_RESOURCE_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, off while reset is low
`define SRV_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is low
`define SRV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/srv_pkg.sv */
// Types, constants and helpers of the script resource validator.
package srv_pkg;

  // Internal counter width and output field width
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned OUT_BITS   = 24;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NONTEXT = 3'd2,
    ST_TAIL    = 3'd3,
    ST_NOMAGIC = 3'd4,
    ST_NOTERM  = 3'd5
  } srv_status_e;

  // Byte classes seen by the line scanner
  typedef enum logic [3:0] {
    CL_NUL,
    CL_LF,
    CL_SEP,
    CL_CR,
    CL_DOT,
    CL_DOLLAR,
    CL_SKIP,
    CL_GT,
    CL_T,
    CL_S,
    CL_C,
    CL_OTHER
  } srv_cls_e;

  // Token match states of one line
  typedef enum logic [3:0] {
    TM_LEAD,
    TM_SKIP,
    TM_NOTOK,
    TM_T1,
    TM_T2,
    TM_T3,
    TM_T4,
    TM_T4CR,
    TM_MT,
    TM_D1,
    TM_D1CR,
    TM_MD
  } srv_tm_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } srv_in_t;

  typedef struct packed {
    srv_status_e         status;
    logic [OUT_BITS-1:0] text_length;
    logic [OUT_BITS-1:0] padding_length;
    logic [OUT_BITS-1:0] line_count;
  } srv_res_t;

  // Classified beat passed from front to back
  typedef struct packed {
    logic     has_byte;
    logic     last;
    srv_cls_e cls;
    logic     bad;
  } srv_item_t;

  typedef logic [COUNT_BITS-1:0] srv_cnt_t;

  function automatic srv_cnt_t sat_inc(input srv_cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Clamp a count to the output width, whatever COUNT_BITS is
  function automatic logic [OUT_BITS-1:0] out_clamp(input srv_cnt_t v);
    logic [COUNT_BITS+OUT_BITS-1:0] wide;
    logic [COUNT_BITS+OUT_BITS-1:0] lim;
    wide = {{OUT_BITS{1'b0}}, v};
    lim  = {{COUNT_BITS{1'b0}}, {OUT_BITS{1'b1}}};
    return (wide > lim) ? {OUT_BITS{1'b1}} : wide[OUT_BITS-1:0];
  endfunction

endpackage

/* rtl/srv_front.sv */
// Front end: takes input beats and classifies each byte for the scanner.
module srv_front (
  input  srv_pkg::srv_in_t   in_i,
  input  logic               push_i,
  input  logic               q_full_i,
  output logic               full_o,
  output logic               q_push_o,
  output srv_pkg::srv_item_t q_item_o
);
  import srv_pkg::*;

  logic [7:0] c;
  assign c = in_i.data_byte;

  // Accept whenever the queue has room; idle marker beats are dropped
  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i && (in_i.has_byte || in_i.last);

  // Byte class and text legality
  always_comb begin
    q_item_o.has_byte = in_i.has_byte;
    q_item_o.last     = in_i.last;
    q_item_o.bad      = !(c inside {[8'h20:8'h7E], 8'h09, 8'h0A, 8'h0D});
    case (c)
      8'h00:   q_item_o.cls = CL_NUL;
      8'h0A:   q_item_o.cls = CL_LF;
      8'h20,
      8'h09:   q_item_o.cls = CL_SEP;
      8'h0D:   q_item_o.cls = CL_CR;
      8'h2E:   q_item_o.cls = CL_DOT;
      8'h24:   q_item_o.cls = CL_DOLLAR;
      8'h23,
      8'h3C:   q_item_o.cls = CL_SKIP;
      8'h3E:   q_item_o.cls = CL_GT;
      8'h54:   q_item_o.cls = CL_T;
      8'h53:   q_item_o.cls = CL_S;
      8'h43:   q_item_o.cls = CL_C;
      default: q_item_o.cls = CL_OTHER;
    endcase
  end

endmodule

/* rtl/srv_fifo.sv */
// Short queue of classified beats between front and back.
module srv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  srv_pkg::srv_item_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output srv_pkg::srv_item_t rdata_o
);
  import srv_pkg::*;

  srv_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/srv_back.sv */
// Back end: line scanner, counters, status and the result register.
module srv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  srv_pkg::srv_item_t q_item_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output srv_pkg::srv_res_t  res_o
);
  import srv_pkg::*;

  typedef struct packed {
    srv_tm_e tm;
    logic    gt;
    logic    mag;
    logic    term;
  } line_t;

  // Close a line: record a match unless it ended in '>'
  function automatic line_t finish_line(input line_t l);
    line_t r;
    r = l;
    if (!l.gt) begin
      if (l.tm inside {TM_T4, TM_T4CR, TM_MT}) r.mag = 1'b1;
      if (l.tm inside {TM_D1, TM_D1CR, TM_MD}) r.term = 1'b1;
    end
    r.tm = TM_LEAD;
    r.gt = 1'b0;
    return r;
  endfunction

  // Advance the token matcher by one text byte
  function automatic line_t scan_char(input line_t l, input srv_cls_e c);
    line_t r;
    logic  sep;
    logic  ws;
    r   = l;
    sep = (c == CL_SEP);
    ws  = sep || (c == CL_CR);
    if (!ws) r.gt = (c == CL_GT);
    case (l.tm)
      TM_LEAD: begin
        if (!ws) begin
          case (c)
            CL_SKIP:   r.tm = TM_SKIP;
            CL_DOT:    r.tm = TM_T1;
            CL_DOLLAR: r.tm = TM_D1;
            default:   r.tm = TM_NOTOK;
          endcase
        end
      end
      TM_T1: r.tm = (c == CL_T) ? TM_T2 : TM_NOTOK;
      TM_T2: r.tm = (c == CL_S) ? TM_T3 : TM_NOTOK;
      TM_T3: r.tm = (c == CL_C) ? TM_T4 : TM_NOTOK;
      TM_T4: r.tm = sep ? TM_MT : (c == CL_CR) ? TM_T4CR : TM_NOTOK;
      TM_D1: r.tm = sep ? TM_MD : (c == CL_CR) ? TM_D1CR : TM_NOTOK;
      TM_T4CR,
      TM_D1CR: begin
        if (!ws) r.tm = TM_NOTOK;
      end
      TM_SKIP,
      TM_NOTOK,
      TM_MT,
      TM_MD: r.tm = l.tm;
      default: r.tm = TM_NOTOK;
    endcase
    return r;
  endfunction

  logic        in_pad_q, in_pad_d;
  srv_status_e err_q, err_d;
  srv_cnt_t    tcnt_q, tcnt_d;
  srv_cnt_t    pcnt_q, pcnt_d;
  srv_cnt_t    lines_q, lines_d;
  line_t       line_q, line_d;
  logic        res_valid_q, res_valid_d;
  srv_res_t    res_q, res_d;
  logic        take;

  // Hold a closing beat back while the result register is still occupied
  assign take    = q_valid_i && !(q_item_i.last && res_valid_q && !pop_i);
  assign q_pop_o = take;
  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

  // Per-beat update and result build
  always_comb begin
    in_pad_d    = in_pad_q;
    err_d       = err_q;
    tcnt_d      = tcnt_q;
    pcnt_d      = pcnt_q;
    lines_d     = lines_q;
    line_d      = line_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop_i;
    if (take) begin
      if (q_item_i.has_byte) begin
        if (in_pad_q) begin
          pcnt_d = sat_inc(pcnt_q);
          if (q_item_i.cls != CL_NUL && err_q == ST_OK) err_d = ST_TAIL;
        end else if (q_item_i.cls == CL_NUL) begin
          in_pad_d = 1'b1;
          pcnt_d   = sat_inc(pcnt_q);
          line_d   = finish_line(line_q);
        end else begin
          tcnt_d = sat_inc(tcnt_q);
          if (q_item_i.bad && err_q == ST_OK) err_d = ST_NONTEXT;
          if (q_item_i.cls == CL_LF) begin
            line_d  = finish_line(line_q);
            lines_d = sat_inc(lines_q);
          end else begin
            line_d = scan_char(line_q, q_item_i.cls);
          end
        end
      end
      if (q_item_i.last) begin
        line_d = finish_line(line_d);
        if (err_d == ST_NONTEXT)   res_d.status = ST_NONTEXT;
        else if (tcnt_d == '0)     res_d.status = ST_EMPTY;
        else if (err_d == ST_TAIL) res_d.status = ST_TAIL;
        else if (!line_d.mag)      res_d.status = ST_NOMAGIC;
        else if (!line_d.term)     res_d.status = ST_NOTERM;
        else                       res_d.status = ST_OK;
        res_d.text_length    = out_clamp(tcnt_d);
        res_d.padding_length = out_clamp(pcnt_d);
        res_d.line_count     = (tcnt_d == '0) ? '0 : out_clamp(sat_inc(lines_d));
        res_valid_d          = 1'b1;
        // Back to the reset state for the next resource
        in_pad_d = 1'b0;
        err_d    = ST_OK;
        tcnt_d   = '0;
        pcnt_d   = '0;
        lines_d  = '0;
        line_d   = '{tm: TM_LEAD, gt: 1'b0, mag: 1'b0, term: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pad_q    <= 1'b0;
      err_q       <= ST_OK;
      tcnt_q      <= '0;
      pcnt_q      <= '0;
      lines_q     <= '0;
      line_q      <= '{tm: TM_LEAD, gt: 1'b0, mag: 1'b0, term: 1'b0};
      res_valid_q <= 1'b0;
    end else begin
      in_pad_q    <= in_pad_d;
      err_q       <= err_d;
      tcnt_q      <= tcnt_d;
      pcnt_q      <= pcnt_d;
      lines_q     <= lines_d;
      line_q      <= line_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

/* rtl/script_resource_validator_core.sv */
// Top level of the script resource validator core.
// Input channel: one beat per resource byte (push while full is low), with
//   in_i.has_byte marking a valid byte and in_i.last the closing beat; a beat
//   with has_byte low and last high closes an empty resource.
// Result channel: one result per resource on res_o while empty is low,
//   taken with pop.
// Throughput: one beat per cycle while full is low. The front classifies each
//   byte as it is taken and writes it into a four-entry queue; the back
//   scanner retires one queued beat per cycle unless it holds a closing beat.
// Result path: the closing beat is written into the queue; the back builds
//   the result when it retires that beat and registers it in res_q, which
//   drives res_o.
// Stall: while a result waits, the back keeps scanning the next resource and
//   holds only at its closing beat; the queue then fills and full rises.
// Reset: rst_ni clears the queue, the scanner state and the result flag at
//   once; the block takes beats as soon as rst_ni is released.
module script_resource_validator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srv_pkg::srv_in_t  in_i,
  input  logic              push,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output srv_pkg::srv_res_t res_o
);
  import srv_pkg::*;

  logic      q_push, q_full, q_pop, q_valid;
  srv_item_t q_wdata, q_rdata;

  // Classification of incoming beats
  srv_front u_front (
    .in_i     (in_i),
    .push_i   (push),
    .q_full_i (q_full),
    .full_o   (full),
    .q_push_o (q_push),
    .q_item_o (q_wdata)
  );

  // Decoupling queue
  srv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // Scanner and result register
  srv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_rdata),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (res_o)
  );

endmodule

/* rtl/srv_checker.sv */
// Port-level checker for the validator core, bound to its top level.
`include "script_resource_validator_core_macros.svh"

module srv_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input srv_pkg::srv_res_t res_o
);
  import srv_pkg::*;

  logic no_text;
  logic no_lines;
  logic st_empty;

  // Flags taken from the waiting result beat
  assign no_text  = (res_o.text_length == '0);
  assign no_lines = (res_o.line_count == '0);
  assign st_empty = (res_o.status == ST_EMPTY);

  // A waiting result beat holds until taken
  `SRV_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(res_o))

  // Empty status exactly when no text byte was counted
  `SRV_ASSERT_IMPL(a_empty_len, clk_i, rst_ni, !empty, no_text == st_empty)

  // Line count is zero exactly when the text is empty
  `SRV_ASSERT_IMPL(a_lines_len, clk_i, rst_ni, !empty, no_lines == no_text)

endmodule

bind script_resource_validator_core srv_checker u_checker (.*);
